### rtl/core/wildcard_mask_matcher_top_defines.svh
// Assertion macros used by the matcher checker.
// All of them sample on the rising edge of clock.
`ifndef WILDCARD_MASK_MATCHER_TOP_DEFINES_SVH
`define WILDCARD_MASK_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define WMM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wildcard mask matcher: assertion failed");

// Next-cycle implication, off while reset is high.
`define WMM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wildcard mask matcher: assertion failed");

// Next-cycle implication that is also checked across reset.
`define WMM_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("wildcard mask matcher: assertion failed");

`endif

### rtl/core/wmm_pkg.sv
`default_nettype none

package wmm_pkg;

   localparam int PATTERN_DEPTH = 64;
   localparam int POS_W = $clog2(PATTERN_DEPTH);
   localparam int LEN_W = $clog2(PATTERN_DEPTH + 1);

   typedef logic [PATTERN_DEPTH-1:0] pos_vec_type;

   typedef enum logic [1:0] {
      OP_CLEAR      = 2'd0,
      OP_LOAD       = 2'd1,
      OP_TEXT       = 2'd2,
      OP_EMPTY_TEXT = 2'd3
   } opcode_type;

   localparam logic [7:0] STAR_CHAR    = 8'h2A;
   localparam logic [7:0] QUES_CHAR    = 8'h3F;
   localparam logic [7:0] LOWER_A      = 8'h61;
   localparam logic [7:0] LOWER_Z      = 8'h7A;
   localparam logic [7:0] CYR_LOW_LO   = 8'hE0;
   localparam logic [7:0] CYR_LOW_HI   = 8'hFF;
   localparam logic [7:0] CYR_YO_LOW   = 8'hB8;
   localparam logic [7:0] CYR_YO_UP    = 8'hA8;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // cp1251 upper-case fold
   function automatic logic [7:0] fold_byte(input logic [7:0] c);
      logic [7:0] f;
      case (c) inside
         [LOWER_A:LOWER_Z],
         [CYR_LOW_LO:CYR_LOW_HI]: f = c - CASE_OFFSET;
         CYR_YO_LOW:              f = CYR_YO_UP;
         default:                 f = c;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

### rtl/core/wildcard_mask_matcher_top.sv
//  channel | ports                                            | direction
//  --------+--------------------------------------------------+----------
//  req     | req_valid req_stall req_opcode req_byte_value    | in
//          | req_last                                         |
//  rsp     | rsp_valid rsp_stall rsp_matched                  | out
//          | rsp_pattern_overflow                             |
//
//  One item per cycle while no held result stalls the input: a transfer lands
//  in the input register, and one pass through the position vector logic then
//  updates state and, on a text end, loads the result register.
//  Reset is synchronous and clears all masks; no clearing pass is needed.
//  A result held by rsp_stall stops the input register only when it is full.
`default_nettype none

module wildcard_mask_matcher_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  wmm_pkg::opcode_type  req_opcode,
   input  logic [7:0]           req_byte_value,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_matched,
   output logic                 rsp_pattern_overflow
);
   import wmm_pkg::*;

   // Closure of '*' bytes: a star position takes its feed, and runs of
   // stars pass activity along as a segmented prefix OR in log steps.
   function automatic pos_vec_type star_close(input pos_vec_type act,
                                              input logic        act0,
                                              input pos_vec_type star,
                                              input pos_vec_type first);
      pos_vec_type r;
      pos_vec_type lk;
      pos_vec_type r_n;
      pos_vec_type lk_n;
      for (int i = 0; i < PATTERN_DEPTH; i++) begin
         if (i == 0) begin
            r[i]  = star[i] ? (act[i] | act0) : act[i];
            lk[i] = 1'b0;
         end else begin
            r[i]  = star[i] ? (act[i] | (first[i] ? act0 : act[i-1])) : act[i];
            lk[i] = star[i] & ~first[i] & star[i-1];
         end
      end
      for (int k = 1; k < PATTERN_DEPTH; k = k * 2) begin
         r_n  = r;
         lk_n = lk;
         for (int i = k; i < PATTERN_DEPTH; i++) begin
            r_n[i]  = r[i] | (lk[i] & r[i-k]);
            lk_n[i] = lk[i] & lk[i-k];
         end
         r  = r_n;
         lk = lk_n;
      end
      return r;
   endfunction

   // input register
   logic             in_valid_ff, in_valid_in;
   opcode_type       in_op_ff;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;

   // mask store and match state
   logic [7:0]       mask_byte_ff [PATTERN_DEPTH];
   pos_vec_type      end_mark_ff, end_mark_in;
   pos_vec_type      used_ff, used_in;
   pos_vec_type      active_ff, active_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic             any_mask_ff, any_mask_in;
   logic             in_text_ff, in_text_in;
   logic             overflow_ff, overflow_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_matched_ff, rsp_matched_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic             advance;
   logic             take;
   logic             work;
   logic             full;
   logic [POS_W-1:0] wr_idx;
   logic [POS_W-1:0] last_idx;
   pos_vec_type      first;
   pos_vec_type      star;
   pos_vec_type      hit;
   pos_vec_type      init_act;
   pos_vec_type      base;
   pos_vec_type      consumed;
   pos_vec_type      text_act;
   pos_vec_type      eval_act;
   logic             match;

   assign advance   = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign take      = req_valid & ~req_stall;
   assign work      = in_valid_ff & advance;

   assign full     = (length_ff == LEN_W'(PATTERN_DEPTH));
   assign wr_idx   = length_ff[POS_W-1:0];
   assign last_idx = POS_W'(length_ff - LEN_W'(1));

   assign first = {end_mark_ff[PATTERN_DEPTH-2:0], 1'b1};

   always_comb begin
      for (int i = 0; i < PATTERN_DEPTH; i++) begin
         star[i] = used_ff[i] & (mask_byte_ff[i] == STAR_CHAR);
         hit[i]  = used_ff[i] & ((mask_byte_ff[i] == QUES_CHAR) ||
                                 (mask_byte_ff[i] == in_byte_ff));
      end
   end

   assign init_act = star_close('0, 1'b1, star, first);
   assign base     = in_text_ff ? active_ff : init_act;

   always_comb begin
      for (int i = 0; i < PATTERN_DEPTH; i++) begin
         if (star[i]) begin
            consumed[i] = base[i];
         end else if (i == 0) begin
            consumed[i] = ~in_text_ff & hit[i];
         end else begin
            consumed[i] = (first[i] ? ~in_text_ff : base[i-1]) & hit[i];
         end
      end
   end

   // after a byte is consumed the start state is gone
   assign text_act = star_close(consumed, 1'b0, star, first);
   assign eval_act = (in_op_ff == OP_EMPTY_TEXT) ? init_act : text_act;
   assign match    = ~any_mask_ff | (|(end_mark_ff & eval_act));

   always_comb begin
      in_valid_in    = take | (in_valid_ff & ~work);
      end_mark_in    = end_mark_ff;
      used_in        = used_ff;
      active_in      = active_ff;
      length_in      = length_ff;
      any_mask_in    = any_mask_ff;
      in_text_in     = in_text_ff;
      overflow_in    = overflow_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_matched_in = rsp_matched_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      if (work) begin
         case (in_op_ff)
            OP_CLEAR: begin
               end_mark_in = '0;
               used_in     = '0;
               active_in   = '0;
               length_in   = '0;
               any_mask_in = 1'b0;
               in_text_in  = 1'b0;
               overflow_in = 1'b0;
            end
            OP_LOAD: begin
               in_text_in = 1'b0;
               active_in  = '0;
               if (!full) begin
                  end_mark_in[wr_idx] = in_last_ff;
                  used_in[wr_idx]     = 1'b1;
                  length_in           = length_ff + LEN_W'(1);
                  if (in_last_ff) begin
                     any_mask_in = 1'b1;
                  end
               end else begin
                  overflow_in = 1'b1;
                  // close the open mask truncated at its last stored byte
                  if (in_last_ff && length_ff != '0 && !end_mark_ff[last_idx]) begin
                     end_mark_in[last_idx] = 1'b1;
                     any_mask_in           = 1'b1;
                  end
               end
            end
            OP_TEXT: begin
               active_in  = text_act;
               in_text_in = ~in_last_ff;
               if (in_last_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_matched_in = match;
                  rsp_ovf_in     = overflow_ff;
               end
            end
            OP_EMPTY_TEXT: begin
               active_in      = init_act;
               in_text_in     = 1'b0;
               rsp_valid_in   = 1'b1;
               rsp_matched_in = match;
               rsp_ovf_in     = overflow_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         end_mark_ff  <= '0;
         used_ff      <= '0;
         active_ff    <= '0;
         length_ff    <= '0;
         any_mask_ff  <= 1'b0;
         in_text_ff   <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         end_mark_ff  <= end_mark_in;
         used_ff      <= used_in;
         active_ff    <= active_in;
         length_ff    <= length_in;
         any_mask_ff  <= any_mask_in;
         in_text_ff   <= in_text_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff   <= req_opcode;
         in_byte_ff <= fold_byte(req_byte_value);
         in_last_ff <= req_last;
      end
      if (work && in_op_ff == OP_LOAD && !full) begin
         mask_byte_ff[wr_idx] <= in_byte_ff;
      end
      rsp_matched_ff <= rsp_matched_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

endmodule

`default_nettype wire

### rtl/core/wmm_check.sv
`default_nettype none
`include "wildcard_mask_matcher_top_defines.svh"

module wmm_check (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_matched,
   input logic rsp_pattern_overflow
);

   // pipeline is empty after reset, so nothing holds off the input
   `WMM_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid && !req_stall)

   // the input only stalls behind a held result
   `WMM_ASSERT_IMPL(a_stall_needs_result, req_stall, rsp_valid && rsp_stall)

   // an empty result register never stalls the input
   `WMM_ASSERT_IMPL(a_no_stall_when_empty, !rsp_valid, !req_stall)

   // a stalled result transfer holds its payload
   `WMM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_matched) && $stable(rsp_pattern_overflow))

endmodule

bind wildcard_mask_matcher_top wmm_check u_wmm_check (.*);

`default_nettype wire
